/* rtl/i2c_three_byte_write_master_core_macros.svh */
// Assertion macros shared by the I2C three-byte write master RTL.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef I2C_THREE_BYTE_WRITE_MASTER_CORE_MACROS_SVH
`define I2C_THREE_BYTE_WRITE_MASTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define I2C3W_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define I2C3W_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/i2c3w_pkg.sv */
// Package for the I2C three-byte write master: beat types, register map, constants.
// No dependencies.
`timescale 1ns / 1ps

package i2c3w_pkg;

  localparam int unsigned CfgDataW      = 10;
  localparam int unsigned CfgIdxW       = 2;
  localparam int unsigned PhaseCntW     = 10;
  localparam int unsigned QueueDepthDef = 2;

  localparam logic [7:0]           SlaveAddrRst  = 8'd120;
  localparam logic [7:0]           CtrlCmdRst    = 8'd0;
  localparam logic [7:0]           CtrlDataRst   = 8'd64;
  localparam logic [PhaseCntW-1:0] PhaseTicksRst = 10'd2;

  localparam logic [2:0] LastBit  = 3'd7;
  localparam logic [1:0] LastByte = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SLAVE_ADDR  = 2'd0,
    CFG_CTRL_CMD    = 2'd1,
    CFG_CTRL_DATA   = 2'd2,
    CFG_PHASE_TICKS = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    BEAT_TICK    = 1'b0,
    BEAT_REQUEST = 1'b1
  } beat_kind_e;

  typedef struct packed {
    logic       start_request;
    logic       is_data;
    logic [7:0] payload;
    logic       sda_in;
  } in_beat_t;

  typedef struct packed {
    logic       scl;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       frame_done;
    logic [2:0] nack_flags;
  } out_beat_t;

  typedef struct packed {
    beat_kind_e kind;
    in_beat_t   beat;
  } queue_beat_t;

endpackage

/* rtl/i2c_three_byte_write_master_core.sv */
// Top level of the tick-driven I2C three-byte write master.
// Depends on i2c3w_pkg, i2c3w_front and i2c3w_engine.
`timescale 1ns / 1ps

// Tick-driven I2C write master. Every input beat is one bus tick carrying a start request,
// the data/command select, the payload byte and the sampled SDA level; every input beat
// yields exactly one output beat with the SCL/SDA levels to drive for that tick, busy,
// frame_done and the three nack flags (address, control, payload byte). A request seen on
// an idle tick opens a frame on that same tick: START, address, control byte, payload,
// STOP, each bus phase lasting phase_ticks ticks (0 acts as 1). Requests while busy are
// dropped. Rate: one beat per clock sustained while output is not stalled; output valid
// rises after the input accept, through the queue slot and then the output register. The
// front queue (QueueDepth beats) decouples input from output stalls; the phase sequencer
// handles one tick per clock when the output slot is free. Configuration registers (index:
// 0 slave address, 1 command control byte, 2 data control byte, 3 phase_ticks) are set via
// cfg_we_i/cfg_idx_i/cfg_wdata_i by the user only while idle; the block never checks it.
module i2c_three_byte_write_master_core #(
  parameter int unsigned QueueDepth = i2c3w_pkg::QueueDepthDef
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration write port
  input  logic                           cfg_we_i,
  input  logic [i2c3w_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [i2c3w_pkg::CfgDataW-1:0] cfg_wdata_i,
  // tick beats in
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  i2c3w_pkg::in_beat_t            in_data_i,
  // bus level beats out
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output i2c3w_pkg::out_beat_t           out_data_o
);

  logic                   q_valid;
  logic                   q_pop;
  i2c3w_pkg::queue_beat_t q_beat;

  // front: tags and buffers tick beats
  i2c3w_front #(
    .Depth (QueueDepth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_beat_o   (q_beat)
  );

  // back: phase sequencer, one queued tick per clock when the output slot is free
  i2c3w_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_beat_i    (q_beat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/i2c3w_front.sv */
// Front end: accepts input beats, tags them as tick or request, and queues them.
// Depends on i2c3w_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_three_byte_write_master_core_macros.svh"

module i2c3w_front #(
  parameter int unsigned Depth = i2c3w_pkg::QueueDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  i2c3w_pkg::in_beat_t    in_data_i,
  output logic                   q_valid_o,
  input  logic                   q_pop_i,
  output i2c3w_pkg::queue_beat_t q_beat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  i2c3w_pkg::queue_beat_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push;
  i2c3w_pkg::queue_beat_t q_entry;

  assign in_ready_o = (count_q != CntW'(Depth));
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (count_q != '0);
  assign q_beat_o   = mem_q[rd_ptr_q];

  always_comb begin
    q_entry.beat = in_data_i;
    q_entry.kind = in_data_i.start_request ? i2c3w_pkg::BEAT_REQUEST : i2c3w_pkg::BEAT_TICK;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      count_d = count_q + 1'b1;
    end else if (!push && q_pop_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= q_entry;
    end
  end

  `I2C3W_ASSERT_IMPL(a_pop_nonempty, q_pop_i, count_q != '0, "pop from empty queue")
  `I2C3W_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(Depth), "queue count overflow")

endmodule

/* rtl/i2c3w_engine.sv */
// Back end: bus phase sequencer, configuration registers and output register.
// Depends on i2c3w_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "i2c_three_byte_write_master_core_macros.svh"

module i2c3w_engine (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [i2c3w_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [i2c3w_pkg::CfgDataW-1:0]    cfg_wdata_i,
  input  logic                              q_valid_i,
  output logic                              q_pop_o,
  input  i2c3w_pkg::queue_beat_t            q_beat_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output i2c3w_pkg::out_beat_t              out_data_o
);

  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_START_A  = 4'd1,
    PH_START_B  = 4'd2,
    PH_HOLD     = 4'd3,
    PH_SETUP    = 4'd4,
    PH_HIGH     = 4'd5,
    PH_ACK_LOW  = 4'd6,
    PH_ACK_HIGH = 4'd7,
    PH_STOP_A   = 4'd8,
    PH_STOP_B   = 4'd9,
    PH_STOP_C   = 4'd10
  } phase_e;

  localparam int unsigned CntW = i2c3w_pkg::PhaseCntW;

  // configuration
  logic [7:0]      slave_q, ctrl_cmd_q, ctrl_data_q;
  logic [CntW-1:0] ticks_q;

  // sequencer
  phase_e          phase_q, phase_d, cur;
  logic [CntW-1:0] cnt_q, cnt_d, cnt_inc, limit;
  logic [2:0]      bit_q, bit_d;
  logic [1:0]      byte_q, byte_d;
  logic [7:0]      shift_q, shift_d, pay_q, pay_d;
  logic            isd_q, isd_d;
  logic [2:0]      ack_q, ack_d;
  logic            scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
  logic            bit_v, busy, done;

  // output register
  logic                 out_valid_q, out_valid_d;
  i2c3w_pkg::out_beat_t out_q, out_d;
  logic                 pop;

  assign pop         = q_valid_i && (!out_valid_q || out_ready_i);
  assign q_pop_o     = pop;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    bit_d   = bit_q;
    byte_d  = byte_q;
    shift_d = shift_q;
    pay_d   = pay_q;
    isd_d   = isd_q;
    ack_d   = ack_q;
    scl_d   = scl_q;
    sda_d   = sda_q;
    drv_d   = drv_q;
    busy    = 1'b0;
    done    = 1'b0;
    cnt_inc = '0;
    bit_v   = shift_q[7];
    limit   = (ticks_q == '0) ? CntW'(1) : ticks_q;

    if (phase_q == PH_IDLE && q_beat_i.kind == i2c3w_pkg::BEAT_REQUEST) begin
      pay_d   = q_beat_i.beat.payload;
      isd_d   = q_beat_i.beat.is_data;
      ack_d   = '0;
      byte_d  = '0;
      bit_d   = '0;
      shift_d = slave_q;
      cnt_d   = '0;
      phase_d = PH_START_A;
      bit_v   = slave_q[7];
    end
    cur = phase_d;

    case (cur)
      PH_START_A: begin
        scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b1;
      end
      PH_START_B: begin
        scl_d = 1'b1; sda_d = 1'b0; drv_d = 1'b1;
      end
      PH_HOLD: begin
        scl_d = 1'b0; drv_d = 1'b1;
      end
      PH_SETUP: begin
        scl_d = 1'b0; sda_d = bit_v; drv_d = 1'b1;
      end
      PH_HIGH: begin
        scl_d = 1'b1; sda_d = bit_v; drv_d = 1'b1;
      end
      PH_ACK_LOW: begin
        scl_d = 1'b0; drv_d = 1'b0;
      end
      PH_ACK_HIGH: begin
        scl_d = 1'b1; drv_d = 1'b0;
      end
      PH_STOP_A: begin
        scl_d = 1'b0; sda_d = 1'b0; drv_d = 1'b1;
      end
      PH_STOP_B: begin
        scl_d = 1'b1; sda_d = 1'b0; drv_d = 1'b1;
      end
      PH_STOP_C: begin
        scl_d = 1'b1; sda_d = 1'b1; drv_d = 1'b1;
      end
      default: begin
        cur     = PH_IDLE;
        phase_d = PH_IDLE;
        scl_d   = 1'b1; sda_d = 1'b1; drv_d = 1'b1;
      end
    endcase

    if (cur != PH_IDLE) begin
      busy    = 1'b1;
      cnt_inc = cnt_d + 1'b1;
      cnt_d   = cnt_inc;
      if (cnt_inc == '0 || cnt_inc >= limit) begin
        cnt_d = '0;
        case (cur)
          PH_START_A: phase_d = PH_START_B;
          PH_START_B: begin
            bit_d   = '0;
            phase_d = PH_HOLD;
          end
          PH_HOLD:    phase_d = PH_SETUP;
          PH_SETUP:   phase_d = PH_HIGH;
          PH_HIGH: begin
            if (bit_d == i2c3w_pkg::LastBit) begin
              phase_d = PH_ACK_LOW;
            end else begin
              bit_d   = bit_d + 1'b1;
              shift_d = {shift_d[6:0], 1'b0};
              phase_d = PH_HOLD;
            end
          end
          PH_ACK_LOW: phase_d = PH_ACK_HIGH;
          PH_ACK_HIGH: begin
            // high level at the end of the ack clock is a nack
            if (q_beat_i.beat.sda_in) begin
              ack_d[byte_d] = 1'b1;
            end
            if (byte_d == i2c3w_pkg::LastByte) begin
              phase_d = PH_STOP_A;
            end else begin
              byte_d  = byte_d + 1'b1;
              shift_d = (byte_d == 2'd1) ? (isd_d ? ctrl_data_q : ctrl_cmd_q) : pay_d;
              bit_d   = '0;
              phase_d = PH_HOLD;
            end
          end
          PH_STOP_A:  phase_d = PH_STOP_B;
          PH_STOP_B:  phase_d = PH_STOP_C;
          default: begin
            done    = 1'b1;
            phase_d = PH_IDLE;
          end
        endcase
      end
    end

    out_d.scl        = scl_d;
    out_d.sda_out    = drv_d ? sda_d : 1'b1;
    out_d.sda_drive  = drv_d;
    out_d.busy_res   = busy;
    out_d.frame_done = done;
    out_d.nack_flags = ack_d;

    out_valid_d = out_valid_q;
    if (pop) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slave_q     <= i2c3w_pkg::SlaveAddrRst;
      ctrl_cmd_q  <= i2c3w_pkg::CtrlCmdRst;
      ctrl_data_q <= i2c3w_pkg::CtrlDataRst;
      ticks_q     <= i2c3w_pkg::PhaseTicksRst;
    end else if (cfg_we_i) begin
      case (i2c3w_pkg::cfg_idx_e'(cfg_idx_i))
        i2c3w_pkg::CFG_SLAVE_ADDR:  slave_q     <= cfg_wdata_i[7:0];
        i2c3w_pkg::CFG_CTRL_CMD:    ctrl_cmd_q  <= cfg_wdata_i[7:0];
        i2c3w_pkg::CFG_CTRL_DATA:   ctrl_data_q <= cfg_wdata_i[7:0];
        i2c3w_pkg::CFG_PHASE_TICKS: ticks_q     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      cnt_q       <= '0;
      bit_q       <= '0;
      byte_q      <= '0;
      shift_q     <= '0;
      pay_q       <= '0;
      isd_q       <= 1'b0;
      ack_q       <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      drv_q       <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop) begin
        phase_q <= phase_d;
        cnt_q   <= cnt_d;
        bit_q   <= bit_d;
        byte_q  <= byte_d;
        shift_q <= shift_d;
        pay_q   <= pay_d;
        isd_q   <= isd_d;
        ack_q   <= ack_d;
        scl_q   <= scl_d;
        sda_q   <= sda_d;
        drv_q   <= drv_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  `I2C3W_ASSERT_IMPL(a_done_busy, out_valid_q && out_q.frame_done, out_q.busy_res, "done without busy")
  `I2C3W_ASSERT_IMPL(a_idle_lines, phase_q == PH_IDLE, scl_q && sda_q && drv_q, "idle bus not released high")
  `I2C3W_ASSERT_IMPL(a_release_ack, !drv_q, phase_q == PH_ACK_LOW || phase_q == PH_ACK_HIGH || phase_q == PH_HOLD || phase_q == PH_STOP_A, "sda released outside ack")

endmodule

/* sim/i2c_three_byte_write_master_core_test.sv */
// Self-checking testbench for the tick-driven I2C three-byte write master.
// Depends on i2c3w_pkg and i2c_three_byte_write_master_core; beats are checked by an
// in-bench bus-level predictor held in a small scoreboard class.
`timescale 1ns / 1ps

module i2c_three_byte_write_master_core_test;

  localparam int unsigned CntW  = i2c3w_pkg::PhaseCntW;
  localparam int unsigned IdxW  = i2c3w_pkg::CfgIdxW;
  localparam int unsigned DataW = i2c3w_pkg::CfgDataW;

  // Bus phases of the predictor, in frame order.
  typedef enum logic [3:0] {
    BP_IDLE,
    BP_START_LEAD,   // scl high, sda high
    BP_START_FALL,   // scl high, sda low
    BP_BIT_HOLD,     // scl low, sda unchanged
    BP_BIT_SETUP,    // scl low, sda = bit
    BP_BIT_HIGH,     // scl high, sda = bit
    BP_ACK_LOW,      // released
    BP_ACK_HIGH,     // released, ack sampled on last tick
    BP_STOP_LOW,
    BP_STOP_RISE,
    BP_STOP_DONE
  } bus_phase_e;

  // How the stimulus drives the sampled data line.
  typedef enum logic [1:0] {
    ACK_ALL,
    NACK_ALL,
    ACK_RANDOM
  } ack_style_e;

  // Tracks the expected line levels for every accepted tick beat.
  class i2c_frame_board;
    logic [7:0]                  addr_reg, cmd_ctrl_reg, data_ctrl_reg;
    logic [CntW-1:0]             ticks_reg;
    bus_phase_e                  phase;
    logic [CntW-1:0]             tick_cnt;
    logic [3:0]                  bit_idx;
    logic [1:0]                  byte_idx;
    logic [7:0]                  shifter, held_byte;
    logic                        held_data;
    logic [2:0]                  nacks;
    logic                        scl_lvl, sda_lvl, drv_lvl;
    i2c3w_pkg::out_beat_t        levels_due[$];
    int unsigned                 tick_count, frames_opened, frames_closed, nack_frames, fails;

    function new();
      addr_reg      = i2c3w_pkg::SlaveAddrRst;
      cmd_ctrl_reg  = i2c3w_pkg::CtrlCmdRst;
      data_ctrl_reg = i2c3w_pkg::CtrlDataRst;
      ticks_reg     = i2c3w_pkg::PhaseTicksRst;
      phase         = BP_IDLE;
      tick_cnt      = '0;
      bit_idx       = '0;
      byte_idx      = '0;
      shifter       = '0;
      held_byte     = '0;
      held_data     = 1'b0;
      nacks         = '0;
      scl_lvl       = 1'b1;
      sda_lvl       = 1'b1;
      drv_lvl       = 1'b1;
    endfunction

    function void set_reg(i2c3w_pkg::cfg_idx_e idx, logic [DataW-1:0] val);
      case (idx)
        i2c3w_pkg::CFG_SLAVE_ADDR:  addr_reg      = val[7:0];
        i2c3w_pkg::CFG_CTRL_CMD:    cmd_ctrl_reg  = val[7:0];
        i2c3w_pkg::CFG_CTRL_DATA:   data_ctrl_reg = val[7:0];
        i2c3w_pkg::CFG_PHASE_TICKS: ticks_reg     = val;
        default: ;
      endcase
    endfunction

    // Advance the bus sequencer by one tick and return the levels it drives.
    function i2c3w_pkg::out_beat_t next_levels(i2c3w_pkg::in_beat_t b);
      logic [CntW-1:0]      lim;
      logic                 busy, done;
      i2c3w_pkg::out_beat_t o;
      lim  = (ticks_reg == '0) ? CntW'(1) : ticks_reg;
      busy = 1'b0;
      done = 1'b0;
      // a request on an idle tick opens the frame on that same tick
      if (phase == BP_IDLE && b.start_request) begin
        held_byte = b.payload;
        held_data = b.is_data;
        nacks     = '0;
        byte_idx  = '0;
        bit_idx   = '0;
        shifter   = addr_reg;
        tick_cnt  = '0;
        phase     = BP_START_LEAD;
        frames_opened++;
      end
      case (phase)
        BP_START_LEAD: begin scl_lvl = 1'b1; sda_lvl = 1'b1; drv_lvl = 1'b1; end
        BP_START_FALL: begin scl_lvl = 1'b1; sda_lvl = 1'b0; drv_lvl = 1'b1; end
        BP_BIT_HOLD:   begin scl_lvl = 1'b0; drv_lvl = 1'b1; end
        BP_BIT_SETUP:  begin scl_lvl = 1'b0; sda_lvl = shifter[7]; drv_lvl = 1'b1; end
        BP_BIT_HIGH:   begin scl_lvl = 1'b1; sda_lvl = shifter[7]; drv_lvl = 1'b1; end
        BP_ACK_LOW:    begin scl_lvl = 1'b0; drv_lvl = 1'b0; end
        BP_ACK_HIGH:   begin scl_lvl = 1'b1; drv_lvl = 1'b0; end
        BP_STOP_LOW:   begin scl_lvl = 1'b0; sda_lvl = 1'b0; drv_lvl = 1'b1; end
        BP_STOP_RISE:  begin scl_lvl = 1'b1; sda_lvl = 1'b0; drv_lvl = 1'b1; end
        BP_STOP_DONE:  begin scl_lvl = 1'b1; sda_lvl = 1'b1; drv_lvl = 1'b1; end
        default: begin
          phase   = BP_IDLE;
          scl_lvl = 1'b1;
          sda_lvl = 1'b1;
          drv_lvl = 1'b1;
        end
      endcase
      if (phase != BP_IDLE) begin
        busy     = 1'b1;
        tick_cnt = tick_cnt + CntW'(1);
        // compare against the live register: lowering it ends a long phase at once
        if (tick_cnt == '0 || tick_cnt >= lim) begin
          tick_cnt = '0;
          case (phase)
            BP_START_LEAD: phase = BP_START_FALL;
            BP_START_FALL: begin bit_idx = '0; phase = BP_BIT_HOLD; end
            BP_BIT_HOLD:   phase = BP_BIT_SETUP;
            BP_BIT_SETUP:  phase = BP_BIT_HIGH;
            BP_BIT_HIGH: begin
              if (bit_idx >= 4'(i2c3w_pkg::LastBit)) begin
                phase = BP_ACK_LOW;
              end else begin
                bit_idx = bit_idx + 4'd1;
                shifter = shifter << 1;
                phase   = BP_BIT_HOLD;
              end
            end
            BP_ACK_LOW: phase = BP_ACK_HIGH;
            BP_ACK_HIGH: begin
              if (b.sda_in) nacks[byte_idx] = 1'b1;
              if (byte_idx >= i2c3w_pkg::LastByte) begin
                phase = BP_STOP_LOW;
              end else begin
                byte_idx = byte_idx + 2'd1;
                if (byte_idx == 2'd1) shifter = held_data ? data_ctrl_reg : cmd_ctrl_reg;
                else shifter = held_byte;
                bit_idx = '0;
                phase   = BP_BIT_HOLD;
              end
            end
            BP_STOP_LOW:  phase = BP_STOP_RISE;
            BP_STOP_RISE: phase = BP_STOP_DONE;
            default: begin
              done  = 1'b1;
              phase = BP_IDLE;
              frames_closed++;
              if (nacks != '0) nack_frames++;
            end
          endcase
        end
      end
      o.scl        = scl_lvl;
      o.sda_out    = drv_lvl ? sda_lvl : 1'b1;  // released line reads back high
      o.sda_drive  = drv_lvl;
      o.busy_res   = busy;
      o.frame_done = done;
      o.nack_flags = nacks;
      return o;
    endfunction

    function void note_tick(i2c3w_pkg::in_beat_t b);
      levels_due.push_back(next_levels(b));
      tick_count++;
    endfunction

    function void cmp_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        fails++;
      end
    endfunction

    function void check_levels(i2c3w_pkg::out_beat_t got);
      i2c3w_pkg::out_beat_t want;
      if (levels_due.size() == 0) begin
        $error("output beat with no tick pending: %h", got);
        fails++;
        return;
      end
      want = levels_due.pop_front();
      cmp_field("scl", 8'(want.scl), 8'(got.scl));
      cmp_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
      cmp_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
      cmp_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
      cmp_field("frame_done", 8'(want.frame_done), 8'(got.frame_done));
      cmp_field("nack_flags", 8'(want.nack_flags), 8'(got.nack_flags));
    endfunction
  endclass

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [IdxW-1:0]      cfg_idx_i;
  logic [DataW-1:0]     cfg_wdata_i;
  logic                 in_valid;
  logic                 in_ready;
  i2c3w_pkg::in_beat_t  in_data;
  logic                 out_valid;
  logic                 out_ready = 1'b1;
  i2c3w_pkg::out_beat_t out_data;

  i2c_frame_board       board;
  bit                   idle_en;      // random gaps and stalls allowed
  int unsigned          stall_left = 0;
  int unsigned          cfg_writes;

  i2c_three_byte_write_master_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Watchdog: worst case is about fourteen hundred beats each waiting out a full
  // sender gap and a full receiver stall; this leaves several times that.
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // Receiver side: ready drops in random bursts.
  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (idle_en && $urandom_range(0, 15) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Output beats are taken on the rising edge they are handshaken.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) board.check_levels(out_data);
  end

  function automatic i2c3w_pkg::in_beat_t make_tick(logic req, logic isd, logic [7:0] pay,
                                                    logic sda);
    i2c3w_pkg::in_beat_t b;
    b.start_request = req;
    b.is_data       = isd;
    b.payload       = pay;
    b.sda_in        = sda;
    return b;
  endfunction

  // One tick beat; valid may drop first for a random gap.
  task automatic send_tick(i2c3w_pkg::in_beat_t b);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk_i); while (!in_ready);
    board.note_tick(b);
  endtask

  task automatic run_ticks(int unsigned count, int unsigned req_pct, ack_style_e style);
    i2c3w_pkg::in_beat_t b;
    repeat (count) begin
      b.start_request = ($urandom_range(1, 100) <= req_pct);
      b.is_data       = 1'($urandom_range(0, 1));
      b.payload       = 8'($urandom_range(0, 255));
      case (style)
        ACK_ALL:  b.sda_in = 1'b0;
        NACK_ALL: b.sda_in = 1'b1;
        default:  b.sda_in = 1'($urandom_range(0, 1));
      endcase
      send_tick(b);
    end
  endtask

  // Stop sending and wait for every pending output beat.
  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (board.levels_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(i2c3w_pkg::cfg_idx_e idx, logic [DataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    board.set_reg(idx, val);
    cfg_writes++;
  endtask

  initial begin
    int unsigned round_len;
    logic [DataW-1:0] ticks_pick;
    board       = new();
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = i2c3w_pkg::CFG_SLAVE_ADDR;
    cfg_wdata_i = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    idle_en     = 1'b1;
    cfg_writes  = 0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset register values: idle tick, a data frame, requests while busy dropped.
    send_tick(make_tick(1'b0, 1'b1, 8'h00, 1'b1));
    send_tick(make_tick(1'b1, 1'b1, 8'hA5, 1'b0));
    send_tick(make_tick(1'b1, 1'b0, 8'hFF, 1'b1));
    send_tick(make_tick(1'b1, 1'b1, 8'h3C, 1'b0));
    run_ticks(180, 0, ACK_ALL);
    drain();

    // Zero phase length acts as one; all-ones command frame, every byte nacked,
    // then back-to-back frames with a request on every tick.
    write_reg(i2c3w_pkg::CFG_SLAVE_ADDR, 10'h0FF);
    write_reg(i2c3w_pkg::CFG_CTRL_CMD, 10'h0FF);
    write_reg(i2c3w_pkg::CFG_CTRL_DATA, 10'h000);
    write_reg(i2c3w_pkg::CFG_PHASE_TICKS, 10'd0);
    send_tick(make_tick(1'b1, 1'b0, 8'hFF, 1'b1));
    run_ticks(90, 0, NACK_ALL);
    run_ticks(120, 100, ACK_RANDOM);
    drain();

    // Zero address and payload, all-ones data control byte on a data frame, one tick per phase.
    write_reg(i2c3w_pkg::CFG_SLAVE_ADDR, 10'h000);
    write_reg(i2c3w_pkg::CFG_CTRL_CMD, 10'h000);
    write_reg(i2c3w_pkg::CFG_CTRL_DATA, 10'h0FF);
    write_reg(i2c3w_pkg::CFG_PHASE_TICKS, 10'd1);
    send_tick(make_tick(1'b1, 1'b1, 8'h00, 1'b0));
    run_ticks(120, 30, ACK_RANDOM);
    drain();

    // Longest phase, then shorten it mid-phase so the current phase ends at once.
    write_reg(i2c3w_pkg::CFG_PHASE_TICKS, 10'd1023);
    send_tick(make_tick(1'b1, 1'b0, 8'h5A, 1'b0));
    run_ticks(40, 50, ACK_RANDOM);
    drain();
    write_reg(i2c3w_pkg::CFG_PHASE_TICKS, 10'd3);
    run_ticks(150, 50, ACK_RANDOM);
    drain();

    // Random rounds: fresh registers each round (often landing mid-frame),
    // small phase lengths, mixed request density and ack behavior.
    while (board.tick_count < 1300) begin
      idle_en = (board.tick_count < 1100) ? ($urandom_range(0, 3) != 0) : 1'b0;
      write_reg(i2c3w_pkg::CFG_SLAVE_ADDR, DataW'($urandom_range(0, 255)));
      write_reg(i2c3w_pkg::CFG_CTRL_CMD, DataW'($urandom_range(0, 255)));
      write_reg(i2c3w_pkg::CFG_CTRL_DATA, DataW'($urandom_range(0, 255)));
      ticks_pick = ($urandom_range(0, 9) == 0) ? '0 : DataW'($urandom_range(1, 4));
      write_reg(i2c3w_pkg::CFG_PHASE_TICKS, ticks_pick);
      round_len = $urandom_range(60, 120);
      case ($urandom_range(0, 5))
        0:       run_ticks(round_len, 2, ACK_RANDOM);
        1:       run_ticks(round_len, 80, ACK_ALL);
        2:       run_ticks(round_len, 80, NACK_ALL);
        default: run_ticks(round_len, 60, ACK_RANDOM);
      endcase
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("Run covered %0d tick beats, %0d register writes, %0d frames opened,",
             board.tick_count, cfg_writes, board.frames_opened);
    $display("%0d frames closed, %0d of them with at least one nack.",
             board.frames_closed, board.nack_frames);
    if (board.fails == 0 && board.levels_due.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
